[hw/rtl/indexed_fifo_queue_top_defines.svh]
// ============================================================================
// Indexed FIFO queue assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ============================================================================
`ifndef INDEXED_FIFO_QUEUE_TOP_DEFINES_SVH
`define INDEXED_FIFO_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define IFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen
`define IFQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define IFQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define IFQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/ifq_pkg.sv]
// ============================================================================
// Indexed FIFO queue package
// Sizes, operation and status codes, control types and the ring slot helper.
// ============================================================================
`timescale 1ns / 1ps

package ifq_pkg;

    // Storage size
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;

    // Port field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 8;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int RD_W     = 8;
    localparam int ECNT_W   = 5;

    // Derived internal widths
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int SUM_W = POS_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_UPD  = 2'd2,
        OP_SWAP = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Write address/data source
    typedef enum logic [1:0] {
        WR_REQ,
        WR_SWAP_A,
        WR_SWAP_B
    } t_wr_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP_B
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    commit;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_status code;
        logic    req_write;
        logic    swap_move;
    } t_dp_status;

    // Ring slot of a position counted from the head
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [POS_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

[hw/rtl/ifq_datapath.sv]
// ============================================================================
// Indexed FIFO queue datapath
// Request capture, ring storage, head/count, checks and result register.
// ============================================================================
`timescale 1ns / 1ps

module ifq_datapath
    import ifq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [DATA_W-1:0]   i_data,
    input  logic [IDX_W-1:0]    i_index_a,
    input  logic [IDX_W-1:0]    i_index_b,
    output logic [STATUS_W-1:0] o_status_code,
    output logic [RD_W-1:0]     o_read_data,
    output logic [ECNT_W-1:0]   o_entry_count
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_data;
    logic [IDX_W-1:0]      r_ia;
    logic [IDX_W-1:0]      r_ib;
    logic [PTR_W-1:0]      r_slot_a;
    logic [PTR_W-1:0]      r_slot_b;
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;
    logic [PTR_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_count;
    logic [PTR_W-1:0]      n_head;
    logic [CNT_W-1:0]      n_count;

    logic [STATUS_W-1:0]   r_res_status;
    logic [RD_W-1:0]       r_res_data;
    logic [ECNT_W-1:0]     r_res_count;

    logic [PTR_W-1:0]      w_rd_addr_a;
    logic [PTR_W-1:0]      w_rd_addr_b;
    logic [PTR_W-1:0]      w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_a_bad;
    logic                  w_b_bad;
    t_status               w_code;
    logic [RD_W-1:0]       w_res_data;

    // Read slots from the incoming request; dequeue reads the head
    always_comb begin
        if (t_op'(i_operation) == OP_DEQ) begin
            w_rd_addr_a = r_head;
        end else begin
            w_rd_addr_a = slot_of(r_head, POS_W'(i_index_a));
        end
        w_rd_addr_b = slot_of(r_head, POS_W'(i_index_b));
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_operation);
            r_data   <= DATA_WIDTH'(i_data);
            r_ia     <= i_index_a;
            r_ib     <= i_index_b;
            r_slot_a <= w_rd_addr_a;
            r_slot_b <= w_rd_addr_b;
        end
    end

    // Checks against the current count
    always_comb begin
        w_empty = (r_count == '0);
        w_full  = (r_count == CNT_W'(DEPTH));
        w_a_bad = (POS_W'(r_ia) >= POS_W'(r_count));
        w_b_bad = (POS_W'(r_ib) >= POS_W'(r_count));
        case (r_op)
            OP_ENQ:  w_code = w_full ? ST_FULL : ST_OK;
            OP_DEQ:  w_code = w_empty ? ST_EMPTY : ST_OK;
            OP_UPD:  w_code = w_empty ? ST_EMPTY : (w_a_bad ? ST_NOT_FOUND : ST_OK);
            OP_SWAP: w_code = w_empty ? ST_EMPTY :
                              ((w_a_bad || w_b_bad) ? ST_NOT_FOUND : ST_OK);
            default: w_code = ST_OK;
        endcase
    end

    assign o_status.code      = w_code;
    assign o_status.req_write = (w_code == ST_OK) && ((r_op == OP_ENQ) || (r_op == OP_UPD));
    assign o_status.swap_move = (w_code == ST_OK) && (r_op == OP_SWAP) && (r_ia != r_ib);

    // Write port source
    always_comb begin
        case (i_cmd.wr_sel)
            WR_REQ: begin
                w_wr_addr = (r_op == OP_ENQ) ? slot_of(r_head, POS_W'(r_count)) : r_slot_a;
                w_wr_data = r_data;
            end
            WR_SWAP_A: begin
                w_wr_addr = r_slot_a;
                w_wr_data = r_rd_b;
            end
            WR_SWAP_B: begin
                w_wr_addr = r_slot_b;
                w_wr_data = r_rd_a;
            end
            default: begin
                w_wr_addr = r_slot_a;
                w_wr_data = r_data;
            end
        endcase
    end

    // Entry memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.capture) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    // Head and count after the step
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (w_code == ST_OK) begin
            case (r_op)
                OP_ENQ: n_count = r_count + 1'b1;
                OP_DEQ: begin
                    n_head  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Result payload
    always_comb begin
        if (r_op == OP_DEQ && w_code == ST_OK) begin
            w_res_data = RD_W'(r_rd_a);
        end else if (r_op == OP_DEQ) begin
            w_res_data = RD_W'({DATA_WIDTH{1'b1}});
        end else begin
            w_res_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_status <= w_code;
            r_res_data   <= w_res_data;
            r_res_count  <= ECNT_W'(n_count);
        end
    end

    assign o_status_code = r_res_status;
    assign o_read_data   = r_res_data;
    assign o_entry_count = r_res_count;

endmodule

[hw/rtl/ifq_ctrl.sv]
// ============================================================================
// Indexed FIFO queue controller
// Sequences capture, memory writes and result commit; owns the output valid.
// ============================================================================
`timescale 1ns / 1ps

module ifq_ctrl
    import ifq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Result register can take a new value this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.capture = 1'b0;
        o_cmd.wr_en   = 1'b0;
        o_cmd.wr_sel  = WR_REQ;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.swap_move) begin
                    // first half of swap: slot A takes B's data
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_SWAP_A;
                    n_state      = S_SWAP_B;
                end else if (w_out_free) begin
                    o_cmd.wr_en  = i_status.req_write;
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SWAP_B: begin
                if (w_out_free) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_SWAP_B;
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/indexed_fifo_queue_top.sv]
// ============================================================================
// Indexed FIFO queue top level
// Bounded FIFO with enqueue, dequeue, update and swap by position from head.
// ============================================================================
// One request is handled at a time and gives one result transfer carrying
// status, dequeued data and the entry count after the step. For enqueue,
// dequeue, update and every failing request, the request is captured with its
// memory read at the input transfer, and the execute state then checks it and
// registers the result. A swap of two distinct positions goes through execute
// and a second swap state before its result is registered, because the entry
// memory has a single write port and the two slots are written in turn. A new
// request is taken the cycle after the result is registered, even while that
// result still waits on the output; a request only stalls in execute or in the
// second swap state when the previous result is still held.
`timescale 1ns / 1ps
`include "indexed_fifo_queue_top_defines.svh"

module indexed_fifo_queue_top
    import ifq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [DATA_W-1:0]   i_data,
    input  logic [IDX_W-1:0]    i_index_a,
    input  logic [IDX_W-1:0]    i_index_b,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [RD_W-1:0]     o_read_data,
    output logic [ECNT_W-1:0]   o_entry_count
);

    t_dp_cmd    w_cmd;
    t_dp_status w_dp_status;

    ifq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_dp_status),
        .o_cmd       (w_cmd)
    );

    ifq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_dp_status),
        .i_operation   (i_operation),
        .i_data        (i_data),
        .i_index_a     (i_index_a),
        .i_index_b     (i_index_b),
        .o_status_code (o_status),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count)
    );

    // A commit never overwrites a result that is still held
    `IFQ_ASSERT_IMPLIES(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.commit, !o_out_valid || !i_out_stall, "result overwritten while stalled")

    // Second swap write goes out together with the commit
    `IFQ_ASSERT_IMPLIES(a_swap_order, i_clk, i_rst_n, w_cmd.wr_en && (w_cmd.wr_sel == WR_SWAP_B), w_cmd.commit, "second swap write without commit")

    // Output valid rises only from a commit
    `IFQ_ASSERT_IMPLIES(a_valid_from_commit, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd.commit), "result valid without commit")

    // Reported count stays within the depth
    `IFQ_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, o_out_valid && (o_entry_count > ECNT_W'(DEPTH)), "entry count above depth")

endmodule

[sim/tb.sv]
// ============================================================================
// Indexed FIFO queue testbench
// Drives enqueue, dequeue, update and swap requests into the queue, predicts
// each result with a behavioral copy of the ring and compares every result
// transfer field by field. Directed corner cases come first, then a long
// output hold, then random traffic under three idle patterns.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import ifq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        t_status             status;
        logic [RD_W-1:0]     read_data;
        logic [ECNT_W-1:0]   count;
    } t_queue_reply;

    // Block ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_operation = '0;
    logic [DATA_W-1:0]   i_data = '0;
    logic [IDX_W-1:0]    i_index_a = '0;
    logic [IDX_W-1:0]    i_index_b = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [RD_W-1:0]     o_read_data;
    logic [ECNT_W-1:0]   o_entry_count;

    // Queue shadow: ring contents, head slot and occupancy
    logic [DATA_WIDTH-1:0] shadow_ring [DEPTH];
    int                    shadow_head = 0;
    int                    shadow_count = 0;

    t_queue_reply awaited_replies [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    bit filling = 1'b1;

    indexed_fifo_queue_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_data        (i_data),
        .i_index_a     (i_index_a),
        .i_index_b     (i_index_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int ring_slot(input int pos);
        return (shadow_head + pos) % DEPTH;
    endfunction

    // Apply one accepted request to the shadow queue and queue up its reply
    task automatic step_queue_model(input t_op op, input logic [DATA_W-1:0] d,
                                    input logic [IDX_W-1:0] ia,
                                    input logic [IDX_W-1:0] ib);
        t_queue_reply          reply;
        logic [DATA_WIDTH-1:0] swap_tmp;
        int                    sa;
        int                    sb;
        reply.status = ST_OK;
        reply.read_data = '0;
        case (op)
            OP_ENQ: begin
                if (shadow_count >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    shadow_ring[ring_slot(shadow_count)] = d[DATA_WIDTH-1:0];
                    shadow_count++;
                end
            end
            OP_DEQ: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                    reply.read_data = RD_W'({DATA_WIDTH{1'b1}});
                end else begin
                    reply.read_data = RD_W'(shadow_ring[shadow_head]);
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            OP_UPD: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (int'(ia) >= shadow_count) begin
                    reply.status = ST_NOT_FOUND;
                end else begin
                    shadow_ring[ring_slot(int'(ia))] = d[DATA_WIDTH-1:0];
                end
            end
            OP_SWAP: begin
                if (shadow_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (int'(ia) >= shadow_count || int'(ib) >= shadow_count) begin
                    reply.status = ST_NOT_FOUND;
                end else if (ia != ib) begin
                    sa = ring_slot(int'(ia));
                    sb = ring_slot(int'(ib));
                    swap_tmp = shadow_ring[sa];
                    shadow_ring[sa] = shadow_ring[sb];
                    shadow_ring[sb] = swap_tmp;
                end
            end
            default: ;
        endcase
        reply.count = ECNT_W'(shadow_count);
        awaited_replies.push_back(reply);
    endtask

    // Offer one request, with a random gap first, and wait for its transfer.
    // Valid is only lowered when a gap is taken, so it never toggles within a step.
    task automatic send_request(input t_op op, input logic [DATA_W-1:0] d,
                                input logic [IDX_W-1:0] ia, input logic [IDX_W-1:0] ib);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data      <= d;
        i_index_a   <= ia;
        i_index_b   <= ib;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        step_queue_model(op, d, ia, ib);
    endtask

    // Mostly a live position, sometimes anywhere in the index range
    function automatic logic [IDX_W-1:0] pick_position();
        if (shadow_count == 0 || $urandom_range(99) < 15) begin
            return IDX_W'($urandom_range(15));
        end
        return IDX_W'($urandom_range(shadow_count - 1));
    endfunction

    // Random request that drifts between empty and full
    task automatic send_random_request();
        t_op op;
        int  pick;
        if (shadow_count >= DEPTH) begin
            filling = 1'b0;
        end else if (shadow_count == 0) begin
            filling = 1'b1;
        end
        pick = $urandom_range(99);
        if (filling) begin
            op = (pick < 55) ? OP_ENQ : (pick < 70) ? OP_DEQ : (pick < 85) ? OP_UPD : OP_SWAP;
        end else begin
            op = (pick < 15) ? OP_ENQ : (pick < 70) ? OP_DEQ : (pick < 85) ? OP_UPD : OP_SWAP;
        end
        send_request(op, DATA_W'($urandom_range(255)), pick_position(), pick_position());
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result transfers are checked here
    always @(posedge i_clk) begin : reply_check
        t_queue_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch($sformatf("result with nothing awaited: st=%0d rd=%02h cnt=%0d",
                                          o_status, o_read_data, o_entry_count));
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.status || o_read_data !== want.read_data ||
                    o_entry_count !== want.count) begin
                    report_mismatch($sformatf(
                        "got st=%0d rd=%02h cnt=%0d, want st=%0d rd=%02h cnt=%0d",
                        o_status, o_read_data, o_entry_count,
                        want.status, want.read_data, want.count));
                end
            end
        end
    end

    // Receiver stall: random, or a long hold counted down in cycles
    always @(posedge i_clk) begin : recv_stall
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Empty, full, not-found, equal-swap and boundary positions
    task automatic test_directed_cases();
        int k;
        send_idle_pct = 7;
        recv_stall_pct = 74;
        send_request(OP_DEQ, 8'h00, 4'd0, 4'd0);
        send_request(OP_UPD, 8'hFF, 4'd0, 4'd15);
        send_request(OP_SWAP, 8'h00, 4'd15, 4'd0);
        for (k = 0; k < DEPTH; k++) begin
            send_request(OP_ENQ, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'(k * 29 + 7),
                         IDX_W'(k), IDX_W'(15 - k));
        end
        send_request(OP_ENQ, 8'hA5, 4'd0, 4'd0);
        send_request(OP_UPD, 8'h5A, 4'd15, 4'd0);
        send_request(OP_DEQ, 8'hFF, 4'd15, 4'd15);
        send_request(OP_UPD, 8'hC3, 4'd15, 4'd0);
        send_request(OP_SWAP, 8'h00, 4'd0, 4'd15);
        send_request(OP_SWAP, 8'h00, 4'd14, 4'd0);
        send_request(OP_SWAP, 8'h00, 4'd3, 4'd3);
        wait_drained();
    endtask

    // Long output hold while requests keep coming, so the input stalls
    task automatic test_backpressure_hold();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 150;
        for (k = 0; k < 20; k++) begin
            send_random_request();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int k;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (k = 0; k < count; k++) begin
            send_random_request();
        end
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < DEPTH; k++) begin
            shadow_ring[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_backpressure_hold();
        test_random_traffic(130, 7, 74);
        test_random_traffic(130, 74, 7);
        test_random_traffic(140, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_replies.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
